// ===== design/mppc_pkg.sv =====
// Shared types, widths and codes of the multichannel pulse period counter.
`default_nettype none

package mppc_pkg;

    // Widths of the request and response fields.
    localparam int OP_W     = 3;
    localparam int CH_W     = 4;
    localparam int STAMP_W  = 32;
    localparam int SEL_W    = 2;
    localparam int PERIOD_W = 38;
    localparam int HITS_W   = 32;
    localparam int MASK_W   = 16;

    // Default channel count and register reset value.
    localparam int                NUM_CHANNELS_DEFAULT = 10;
    localparam logic [MASK_W-1:0] MASK_RESET           = 16'h03FF;

    // Nanoseconds per timer count.
    localparam logic [PERIOD_W-1:0] TICK_NS_PER_COUNT = 38'd50;

    // Operation codes; the two remaining codes do nothing.
    localparam logic [OP_W-1:0] OP_CAPTURE = 3'd0;
    localparam logic [OP_W-1:0] OP_PULSE   = 3'd1;
    localparam logic [OP_W-1:0] OP_FLOW    = 3'd2;
    localparam logic [OP_W-1:0] OP_LEVEL   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // Flow pulse counter selection.
    localparam logic [SEL_W-1:0] FLOW_SECONDARY = 2'd0;
    localparam logic [SEL_W-1:0] FLOW_PRIMARY   = 2'd1;
    localparam logic [SEL_W-1:0] FLOW_BY_LEVELS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // perform the held request on the channel table
        logic emit;   // load the response register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emits;  // the held request produces a response
    } t_status;

endpackage

`default_nettype wire

// ===== design/mppc_if.sv =====
// Request and response channel interfaces of the pulse period counter.
`default_nettype none

interface mppc_req_if
    import mppc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CH_W-1:0]     channel;
    logic [STAMP_W-1:0]  timestamp;
    logic [SEL_W-1:0]    flow_select;
    logic                level;

    modport source (output valid, operation, channel, timestamp, flow_select, level,
                    input ready);
    modport sink   (input valid, operation, channel, timestamp, flow_select, level,
                    output ready);
endinterface

interface mppc_rsp_if
    import mppc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     snap_channel;
    logic [PERIOD_W-1:0] period_ns;
    logic [HITS_W-1:0]   hit_total;
    logic                stale;

    modport source (output valid, snap_channel, period_ns, hit_total, stale,
                    input ready);
    modport sink   (input valid, snap_channel, period_ns, hit_total, stale,
                    output ready);
endinterface

`default_nettype wire

// ===== design/mppc_ctrl.sv =====
// Controller state machine: request handshake, sequencing and response valid.
`default_nettype none

module mppc_ctrl
    import mppc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    output logic         o_rsp_valid,
    input  wire logic    i_rsp_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_rsp_valid;
    logic   w_stall;

    // A response-producing request waits while the response register is still full.
    always_comb begin
        w_stall      = i_status.emits && r_rsp_valid && !i_rsp_ready;
        o_req_ready  = (r_state == S_IDLE);
        o_cmd.load   = (r_state == S_IDLE) && i_req_valid;
        o_cmd.exec   = (r_state == S_EXEC) && !w_stall;
        o_cmd.emit   = (r_state == S_EXEC) && !w_stall && i_status.emits;
        o_rsp_valid  = r_rsp_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!w_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.emit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/mppc_datapath.sv =====
// Datapath: held request, per-channel table, mode register and response register.
`default_nettype none

module mppc_datapath
    import mppc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [STAMP_W-1:0]  i_timestamp,
    input  wire logic [SEL_W-1:0]    i_flow_select,
    input  wire logic                i_level,
    input  wire logic                i_cfg_we,
    input  wire logic [MASK_W-1:0]   i_cfg_wdata,
    output logic [CH_W-1:0]          o_snap_channel,
    output logic [PERIOD_W-1:0]      o_period_ns,
    output logic [HITS_W-1:0]        o_hit_total,
    output logic                     o_stale
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W:0] NUM_CH = (CH_W+1)'(NUM_CHANNELS);

    // Held request.
    logic [OP_W-1:0]    r_op;
    logic [CH_W-1:0]    r_ch;
    logic [STAMP_W-1:0] r_stamp;
    logic [SEL_W-1:0]   r_sel;
    logic               r_lvl;

    // Channel table.
    logic [STAMP_W-1:0]    r_last_stamp [NUM_CHANNELS];
    logic [PERIOD_W-1:0]   r_interval   [NUM_CHANNELS];
    logic [HITS_W-1:0]     r_hits_pri   [NUM_CHANNELS];
    logic [HITS_W-1:0]     r_hits_snap  [NUM_CHANNELS];
    logic [HITS_W-1:0]     r_hits_sec   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_level;
    logic [CH_W-1:0]       r_turn;
    logic [MASK_W-1:0]     r_mask;

    // Response register.
    logic [CH_W-1:0]     r_snap_channel;
    logic [PERIOD_W-1:0] r_period_ns;
    logic [HITS_W-1:0]   r_hit_total;
    logic                r_stale;

    logic                w_ok;
    logic [CH_W-1:0]     w_turn;
    logic [CH_W-1:0]     n_turn;
    logic [IDX_W-1:0]    w_addr;
    logic [CH_W-1:0]     w_ch_m1;
    logic [CH_W-1:0]     w_ch_m2;
    logic                w_lvl_m1;
    logic                w_lvl_m2;
    logic [STAMP_W-1:0]  w_diff;
    logic [PERIOD_W-1:0] n_interval;
    logic [HITS_W-1:0]   w_rd_pri;
    logic                w_pri_inc;
    logic                w_sec_inc;
    logic                w_stale_now;

    always_comb begin
        w_ok   = ({1'b0, r_ch} < NUM_CH);
        w_turn = ({1'b0, r_turn} < NUM_CH) ? r_turn : '0;
        n_turn = (({1'b0, w_turn} + 1'b1) < NUM_CH) ? CH_W'(w_turn + 1'b1) : '0;
        w_addr = (r_op == OP_TICK) ? w_turn[IDX_W-1:0] : r_ch[IDX_W-1:0];

        // Neighbour levels; a neighbour below channel zero reads as low.
        w_ch_m1  = CH_W'(r_ch - 1'b1);
        w_ch_m2  = CH_W'(r_ch - 2'd2);
        w_lvl_m1 = (r_ch >= CH_W'(1)) ? r_level[w_ch_m1[IDX_W-1:0]] : 1'b0;
        w_lvl_m2 = (r_ch >= CH_W'(2)) ? r_level[w_ch_m2[IDX_W-1:0]] : 1'b0;

        w_rd_pri    = r_hits_pri[w_addr];
        w_diff      = r_stamp - r_last_stamp[w_addr];
        n_interval  = {{(PERIOD_W-STAMP_W){1'b0}}, w_diff} * TICK_NS_PER_COUNT;
        w_stale_now = (r_hits_snap[w_addr] == w_rd_pri);

        w_pri_inc = 1'b0;
        w_sec_inc = 1'b0;
        case (r_op)
            OP_CAPTURE, OP_PULSE: begin
                w_pri_inc = w_ok;
            end
            OP_FLOW: begin
                if (r_sel == FLOW_BY_LEVELS) begin
                    w_pri_inc = w_ok && w_lvl_m2;
                    w_sec_inc = w_ok && !w_lvl_m2 && w_lvl_m1;
                end else if (r_sel == FLOW_SECONDARY) begin
                    w_sec_inc = w_ok;
                end else begin
                    w_pri_inc = w_ok;
                end
            end
            default: begin
                w_pri_inc = 1'b0;
                w_sec_inc = 1'b0;
            end
        endcase

        o_status.emits = (r_op == OP_TICK) && r_mask[w_turn];

        o_snap_channel = r_snap_channel;
        o_period_ns    = r_period_ns;
        o_hit_total    = r_hit_total;
        o_stale        = r_stale;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_ch    <= i_channel;
            r_stamp <= i_timestamp;
            r_sel   <= i_flow_select;
            r_lvl   <= i_level;
        end
        if (i_cmd.emit) begin
            r_snap_channel <= w_turn;
            r_period_ns    <= w_stale_now ? '0 : r_interval[w_addr];
            r_hit_total    <= w_rd_pri;
            r_stale        <= w_stale_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.exec && r_op == OP_CLEAR)) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_last_stamp[c] <= '0;
                r_interval[c]   <= '0;
                r_hits_pri[c]   <= '0;
                r_hits_snap[c]  <= '0;
                r_hits_sec[c]   <= '0;
            end
            r_level <= '0;
            r_turn  <= '0;
        end else if (i_cmd.exec) begin
            if (w_pri_inc) begin
                r_hits_pri[w_addr] <= w_rd_pri + 1'b1;
            end
            if (w_sec_inc) begin
                r_hits_sec[w_addr] <= r_hits_sec[w_addr] + 1'b1;
            end
            if (r_op == OP_CAPTURE && w_ok) begin
                r_interval[w_addr]   <= n_interval;
                r_last_stamp[w_addr] <= r_stamp;
            end
            if (r_op == OP_LEVEL && w_ok) begin
                r_level[r_ch[IDX_W-1:0]] <= r_lvl;
            end
            if (r_op == OP_TICK) begin
                if (r_mask[w_turn]) begin
                    r_hits_snap[w_addr] <= w_rd_pri;
                end
                r_turn <= n_turn;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/multichannel_pulse_period_counter_core.sv =====
// Top level of the multichannel pulse period and pulse counter.
`default_nettype none

// The block keeps a small table of pulse channels. A capture request stores the time
// since the channel's previous capture as 50 ns per timer count (the stamp difference
// taken modulo 2^32), counts a hit and keeps the stamp; a pulse request only counts a
// hit; a flow pulse counts into the primary or secondary counter, chosen directly or by
// the levels of the two channels below; a level update stores the channel's level, and
// a clear request zeroes the whole table and the round-robin pointer, though not the
// mode register. A tick request visits the next channel in turn and, if that channel's
// bit is set in the mode register, returns one response with its last interval (zero
// when no hit has come since its last report), its hit count and a stale flag. Requests
// that address a channel beyond the table do nothing. A request is registered, then
// applied as a read-modify-write of its channel's row; no new request is taken until
// that is done. The response sits in an output register, and further requests are
// taken while it waits; only a tick that must report while the previous response is
// still untaken is held until that response leaves. The user writes the mode register
// through the configuration port only while idle; the block does not enforce this.

module multichannel_pulse_period_counter_core
    import mppc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mppc_req_if.sink               i_req,
    mppc_rsp_if.source             o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [MASK_W-1:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    // The controller owns both handshakes and sequences the datapath.
    mppc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the request, the channel table and the response payload.
    mppc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_operation    (i_req.operation),
        .i_channel      (i_req.channel),
        .i_timestamp    (i_req.timestamp),
        .i_flow_select  (i_req.flow_select),
        .i_level        (i_req.level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_snap_channel (o_rsp.snap_channel),
        .o_period_ns    (o_rsp.period_ns),
        .o_hit_total    (o_rsp.hit_total),
        .o_stale        (o_rsp.stale)
    );

endmodule

`default_nettype wire

// ===== design/mppc_checker.sv =====
// Port-level checker of the pulse period counter, bound to the top level.
`default_nettype none

module mppc_checker
    import mppc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_req_valid,
    input wire logic                i_req_ready,
    input wire logic                i_rsp_valid,
    input wire logic                i_rsp_ready,
    input wire logic [CH_W-1:0]     i_snap_channel,
    input wire logic [PERIOD_W-1:0] i_period_ns,
    input wire logic                i_stale
);

    localparam logic [CH_W:0] NUM_CH = (CH_W+1)'(NUM_CHANNELS);

    // A response held back by the sink stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response withdrawn while stalled");

    // A stale report never carries a period.
    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_stale |-> i_period_ns == '0)
        else $error("stale response with non-zero period");

    // Only channels of the table are reported.
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ({1'b0, i_snap_channel} < NUM_CH))
        else $error("response for a channel outside the table");

    // A new response follows an accepted request that was held and executed.
    a_rsp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("response without a preceding request");

endmodule

bind multichannel_pulse_period_counter_core mppc_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mppc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_snap_channel (o_rsp.snap_channel),
    .i_period_ns    (o_rsp.period_ns),
    .i_stale        (o_rsp.stale)
);

`default_nettype wire

// ===== bench/pulse_table_checker.sv =====
// Checker for the pulse period counter: mirrors the channel table and checks every snapshot.
`timescale 1ns / 1ps

module pulse_table_checker
    import mppc_pkg::*;
#(
    parameter int NUM_CH = NUM_CHANNELS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mppc_req_if               i_req,
    mppc_rsp_if               i_rsp,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [CH_W-1:0]     chan;
        logic [PERIOD_W-1:0] period;
        logic [HITS_W-1:0]   hits;
        logic                stale;
    } t_snapshot;

    t_snapshot           snapshot_q[$];
    logic [MASK_W-1:0]   rpm_mask;
    logic [STAMP_W-1:0]  prev_stamp [NUM_CH];
    logic [PERIOD_W-1:0] period_tab [NUM_CH];
    logic [HITS_W-1:0]   hit_cnt    [NUM_CH];
    logic [HITS_W-1:0]   hit_seen   [NUM_CH];
    logic [HITS_W-1:0]   aux_cnt    [NUM_CH];
    logic                lvl_tab    [NUM_CH];
    int unsigned         turn;
    int                  fault_cnt = 0;

    task automatic clear_table();
        for (int c = 0; c < NUM_CH; c++) begin
            prev_stamp[c] = '0;
            period_tab[c] = '0;
            hit_cnt[c]    = '0;
            hit_seen[c]   = '0;
            aux_cnt[c]    = '0;
            lvl_tab[c]    = 1'b0;
        end
        turn = 0;
    endtask

    // Channels below the table read as level low.
    function automatic logic level_below(int idx);
        if (idx < 0) begin
            return 1'b0;
        end
        return lvl_tab[idx];
    endfunction

    task automatic advance_pulse_table(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                       input logic [STAMP_W-1:0] stamp,
                                       input logic [SEL_W-1:0] sel, input logic lvl);
        logic [STAMP_W-1:0] diff;
        t_snapshot          snap;
        logic               in_range;
        int                 t;
        in_range = int'(ch) < NUM_CH;
        case (op)
            OP_CAPTURE: if (in_range) begin
                diff           = stamp - prev_stamp[ch];
                period_tab[ch] = PERIOD_W'(diff) * TICK_NS_PER_COUNT;
                hit_cnt[ch]    = hit_cnt[ch] + 1'b1;
                prev_stamp[ch] = stamp;
            end
            OP_PULSE: if (in_range) begin
                hit_cnt[ch] = hit_cnt[ch] + 1'b1;
            end
            OP_FLOW: if (in_range) begin
                case (sel)
                    FLOW_SECONDARY: aux_cnt[ch] = aux_cnt[ch] + 1'b1;
                    FLOW_BY_LEVELS: begin
                        if (level_below(int'(ch) - 2)) begin
                            hit_cnt[ch] = hit_cnt[ch] + 1'b1;
                        end else if (level_below(int'(ch) - 1)) begin
                            aux_cnt[ch] = aux_cnt[ch] + 1'b1;
                        end
                    end
                    default: hit_cnt[ch] = hit_cnt[ch] + 1'b1;
                endcase
            end
            OP_LEVEL: if (in_range) begin
                lvl_tab[ch] = lvl;
            end
            OP_TICK: begin
                t = (turn >= NUM_CH) ? 0 : int'(turn);
                if (rpm_mask[t]) begin
                    snap.chan   = CH_W'(t);
                    snap.stale  = hit_seen[t] == hit_cnt[t];
                    snap.period = snap.stale ? '0 : period_tab[t];
                    snap.hits   = hit_cnt[t];
                    hit_seen[t] = hit_cnt[t];
                    snapshot_q.push_back(snap);
                end
                turn = (t + 1 >= NUM_CH) ? 0 : t + 1;
            end
            OP_CLEAR: clear_table();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_snapshot exp_snap;
        t_snapshot got_snap;
        if (!i_rst_n) begin
            clear_table();
            rpm_mask = MASK_RESET;
            snapshot_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got_snap = '{i_rsp.snap_channel, i_rsp.period_ns, i_rsp.hit_total, i_rsp.stale};
                if (snapshot_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("unexpected snapshot: ch %0d period %0d hits %0d stale %0b",
                                 got_snap.chan, got_snap.period, got_snap.hits, got_snap.stale);
                    end
                end else begin
                    exp_snap = snapshot_q.pop_front();
                    if (got_snap.chan != exp_snap.chan || got_snap.period != exp_snap.period ||
                        got_snap.hits != exp_snap.hits || got_snap.stale != exp_snap.stale) begin
                        fault_cnt++;
                        if (fault_cnt <= 10) begin
                            $display("snapshot mismatch: expected ch %0d period %0d hits %0d stale %0b",
                                     exp_snap.chan, exp_snap.period, exp_snap.hits,
                                     exp_snap.stale);
                            $display("                   got      ch %0d period %0d hits %0d stale %0b",
                                     got_snap.chan, got_snap.period, got_snap.hits,
                                     got_snap.stale);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                rpm_mask = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                advance_pulse_table(i_req.operation, i_req.channel, i_req.timestamp,
                                    i_req.flow_select, i_req.level);
            end
        end
        o_pending    <= snapshot_q.size();
        o_fail_count <= fault_cnt;
    end

endmodule

// ===== bench/multichannel_pulse_period_counter_core_tb.sv =====
// Top of the pulse period counter bench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module multichannel_pulse_period_counter_core_tb
    import mppc_pkg::*;
;

    localparam int NUM_CH = NUM_CHANNELS_DEFAULT;

    // The two operation codes that the block must ignore, and the flow select value that
    // has no name of its own but counts like the primary choice.
    localparam logic [OP_W-1:0]  OP_SPARE_A  = 3'd6;
    localparam logic [OP_W-1:0]  OP_SPARE_B  = 3'd7;
    localparam logic [SEL_W-1:0] FLOW_ALIAS  = 2'd3;

    // Number of random requests in the opening phase and in each later mask phase.
    localparam int FIRST_BURST = 300;
    localparam int PHASE_BURST = 270;
    localparam int NUM_PHASES  = 6;

    // Generous cycle budget: every request waits out the longest gap, a held tick the
    // longest receiver stall, and each request its own register and execute steps.
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [MASK_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                cycle_cnt = 0;
    int                rdy_wait  = 0;
    int                rdy_draw;
    bit                pace_on   = 1'b1;
    logic [STAMP_W-1:0] timer_now = '0;
    logic [MASK_W-1:0] phase_mask [NUM_PHASES];

    mppc_req_if req_if ();
    mppc_rsp_if rsp_if ();

    multichannel_pulse_period_counter_core #(
        .NUM_CHANNELS(NUM_CH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    pulse_table_checker #(
        .NUM_CH(NUM_CH)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: a run that hangs is declared failed rather than left spinning.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("multichannel_pulse_period_counter_core regression: fail");
            $finish;
        end
    end

    // The response side stalls after each accepted snapshot for a drawn number of cycles,
    // none at all when the draw is zero. When pacing is off it stays ready throughout, so
    // back-to-back traffic is seen too.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            rdy_wait     <= 0;
        end else if (rdy_wait != 0) begin
            rdy_wait     <= rdy_wait - 1;
            rsp_if.ready <= (rdy_wait == 1);
        end else if (rsp_if.valid && rsp_if.ready && pace_on) begin
            rdy_draw      = $urandom_range(0, 8);
            rdy_wait     <= rdy_draw;
            rsp_if.ready <= (rdy_draw == 0);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Offers one request after a drawn gap and returns at the edge that accepts it. The
    // valid line is only lowered when a gap is taken, so consecutive requests stay
    // back to back without a glitch on valid.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                input logic [STAMP_W-1:0] stamp,
                                input logic [SEL_W-1:0] sel, input logic lvl);
        int gap;
        gap = pace_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.channel     <= ch;
        req_if.timestamp   <= stamp;
        req_if.flow_select <= sel;
        req_if.level       <= lvl;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // A random request, shaped like real traffic: mostly captures and ticks on channels
    // inside the table, with stamps from a running timer so that intervals look like
    // pulse periods, and a minority of wild stamps, stray channels, clears and the two
    // codes that the block should ignore.
    task automatic random_request();
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [CH_W-1:0]    ch;
        logic [STAMP_W-1:0] stamp;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            op = OP_CAPTURE;
        end else if (roll < 43) begin
            op = OP_PULSE;
        end else if (roll < 57) begin
            op = OP_FLOW;
        end else if (roll < 67) begin
            op = OP_LEVEL;
        end else if (roll < 96) begin
            op = OP_TICK;
        end else if (roll < 98) begin
            op = OP_CLEAR;
        end else begin
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end
        if ($urandom_range(0, 9) == 0) begin
            ch = CH_W'($urandom_range(NUM_CH, 15));
        end else begin
            ch = CH_W'($urandom_range(0, NUM_CH - 1));
        end
        if ($urandom_range(0, 3) == 0) begin
            stamp = $urandom;
        end else begin
            timer_now = timer_now + STAMP_W'($urandom_range(0, 200000));
            stamp     = timer_now;
        end
        send_request(op, ch, stamp, SEL_W'($urandom), 1'($urandom));
    endtask

    // Waits until every snapshot owed has been taken. The first edge lets the checker
    // account for the last accepted request; the tail covers a tick that is still in
    // flight on a channel whose snapshot is masked off.
    task automatic drain_requests(input int tail);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_CAPTURE;
        req_if.channel     <= '0;
        req_if.timestamp   <= '0;
        req_if.flow_select <= FLOW_SECONDARY;
        req_if.level       <= 1'b0;

        // Mask settings for the later phases: all channels, none, a sparse pattern, only
        // the bits beyond the table, a random pattern and finally the reset value again.
        phase_mask[0] = 16'hFFFF;
        phase_mask[1] = 16'h0000;
        phase_mask[2] = 16'h0155;
        phase_mask[3] = 16'hFC00;
        phase_mask[4] = MASK_W'($urandom);
        phase_mask[5] = MASK_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset mask. Repeated stamps give a zero interval,
        // the jump from zero to the top stamp gives the largest period, and the following
        // small stamp wraps the timer.
        send_request(OP_CAPTURE, 4'd0, 32'd100,       FLOW_SECONDARY, 1'b0);
        send_request(OP_CAPTURE, 4'd0, 32'd100,       FLOW_SECONDARY, 1'b0);
        send_request(OP_CAPTURE, 4'd9, 32'hFFFF_FFFF, FLOW_SECONDARY, 1'b0);
        send_request(OP_CAPTURE, 4'd9, 32'd5,         FLOW_SECONDARY, 1'b0);
        send_request(OP_PULSE,   4'd1, 32'd0,         FLOW_SECONDARY, 1'b0);

        // Every flow selection, including the unnamed one and the neighbour choice in its
        // three outcomes: the level two below, the level one below, and neither (which
        // also covers neighbours below channel zero).
        send_request(OP_FLOW,  4'd3, 32'd0, FLOW_SECONDARY, 1'b0);
        send_request(OP_FLOW,  4'd3, 32'd0, FLOW_PRIMARY,   1'b0);
        send_request(OP_FLOW,  4'd3, 32'd0, FLOW_ALIAS,     1'b0);
        send_request(OP_LEVEL, 4'd1, 32'd0, FLOW_SECONDARY, 1'b1);
        send_request(OP_FLOW,  4'd3, 32'd0, FLOW_BY_LEVELS, 1'b0);
        send_request(OP_FLOW,  4'd2, 32'd0, FLOW_BY_LEVELS, 1'b0);
        send_request(OP_FLOW,  4'd0, 32'd0, FLOW_BY_LEVELS, 1'b0);
        send_request(OP_LEVEL, 4'd1, 32'd0, FLOW_SECONDARY, 1'b0);

        // Channels beyond the table must leave everything untouched, as must the two
        // spare operation codes.
        send_request(OP_CAPTURE, 4'd15, 32'hA5A5_A5A5, FLOW_SECONDARY, 1'b0);
        send_request(OP_FLOW,    4'd12, 32'd0,         FLOW_PRIMARY,   1'b0);
        send_request(OP_LEVEL,   4'd11, 32'd0,         FLOW_SECONDARY, 1'b1);
        send_request(OP_SPARE_A, 4'd0,  32'hFFFF_FFFF, FLOW_ALIAS,     1'b1);
        send_request(OP_SPARE_B, 4'd9,  32'hFFFF_FFFF, FLOW_ALIAS,     1'b1);

        // One full round of ticks reports every channel, stale ones included; a clear
        // then restarts the round at channel zero.
        for (int i = 0; i < NUM_CH; i++) begin
            send_request(OP_TICK, 4'd0, 32'd0, FLOW_SECONDARY, 1'b0);
        end
        send_request(OP_CLEAR, 4'd0, 32'd0, FLOW_SECONDARY, 1'b0);
        send_request(OP_TICK,  4'd0, 32'd0, FLOW_SECONDARY, 1'b0);

        // Random traffic, first under the reset mask and then under each mask setting in
        // turn. Pacing is redrawn every few dozen requests so that stretches without any
        // gaps or stalls alternate with heavily paced ones.
        for (int n = 0; n < FIRST_BURST; n++) begin
            if (n % 40 == 0) begin
                pace_on = ($urandom_range(0, 3) != 0);
            end
            random_request();
        end
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_requests(8);
            write_mask(phase_mask[p]);
            for (int n = 0; n < PHASE_BURST; n++) begin
                if (n % 40 == 0) begin
                    pace_on = ($urandom_range(0, 3) != 0);
                end
                random_request();
            end
        end

        drain_requests(16);
        if (fail_count == 0 && pending == 0) begin
            $display("multichannel_pulse_period_counter_core regression: pass");
        end else begin
            $display("multichannel_pulse_period_counter_core regression: fail");
        end
        $finish;
    end

endmodule
